[rtl/core/slms_pkg.sv]
// ----------------------------------------------------------------------------
// slms_pkg
// Shared types and constants for the scrolling LED matrix scanner core.
// ----------------------------------------------------------------------------
package slms_pkg;

  localparam int MSG_DEPTH = 256;
  localparam int ADDR_W    = $clog2(MSG_DEPTH);
  localparam int LEN_W     = $clog2(MSG_DEPTH + 1);
  // window index: sign bit plus room for offset + 23 and for the length
  localparam int IDX_W     = ((LEN_W > 9) ? LEN_W : 9) + 1;

  localparam int WIN_COLS  = 24;
  localparam int WIN_IDX_W = $clog2(WIN_COLS);
  localparam int ROWS      = 8;
  localparam int ROW_W     = $clog2(ROWS);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR   = 2'd0;
  localparam cmd_t CMD_APPEND  = 2'd1;
  localparam cmd_t CMD_SCROLL  = 2'd2;
  localparam cmd_t CMD_REFRESH = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPACER,
    ST_SCROLL,
    ST_REFRESH
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  typedef struct packed {
    logic                 en;
    logic [WIN_IDX_W-1:0] idx;
    logic [7:0]           data;
  } win_wr_t;

endpackage

[rtl/core/slms_msg_store.sv]
// ----------------------------------------------------------------------------
// slms_msg_store
// Message column store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module slms_msg_store (
  input  logic                 clk,
  input  slms_pkg::store_req_t req,
  output logic [7:0]           rd_data
);

  logic [7:0] mem [slms_pkg::MSG_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/core/slms_window.sv]
// ----------------------------------------------------------------------------
// slms_window
// 24-column display window with a row transposer for the three matrices.
// ----------------------------------------------------------------------------
module slms_window (
  input  logic                         clk,
  input  logic                         rst,
  input  slms_pkg::win_wr_t            wr,
  input  logic [slms_pkg::ROW_W-1:0]   row,
  output logic [7:0]                   row_left,
  output logic [7:0]                   row_middle,
  output logic [7:0]                   row_right
);

  logic [7:0] cols [slms_pkg::WIN_COLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < slms_pkg::WIN_COLS; i++) begin
        cols[i] <= '0;
      end
    end else if (wr.en) begin
      cols[wr.idx] <= wr.data;
    end
  end

  // bit c of each byte is the selected row of that matrix's column c
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      row_left[c]   = cols[c][row];
      row_middle[c] = cols[c + 8][row];
      row_right[c]  = cols[c + 16][row];
    end
  end

endmodule

[rtl/core/scrolling_led_matrix_scanner_core.sv]
// ----------------------------------------------------------------------------
// scrolling_led_matrix_scanner_core
// Message store, scroll window loader and row scanner for three 8x8 matrices.
// ----------------------------------------------------------------------------
// Clear: taken in idle. Append: one store write, the spacer in a state of its own
//   (one store write port). Scroll: each window column goes through the shared
//   index/compare unit and is read from the store only inside the message, else
//   zero; the last column lands as input reopens. Refresh: 8 row transactions, one
//   per cycle while the output is not stalled.
// Reset clears length, window and control; store contents stay undefined.
module scrolling_led_matrix_scanner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  column_byte,
  input  logic        glyph_end,
  input  logic signed [8:0] scroll_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  row_select,
  output logic [7:0]  cols_left,
  output logic [7:0]  cols_middle,
  output logic [7:0]  cols_right,
  output logic        last_row
);

  localparam int IDX_W     = slms_pkg::IDX_W;
  localparam int ADDR_W    = slms_pkg::ADDR_W;
  localparam int LEN_W     = slms_pkg::LEN_W;
  localparam int WIN_IDX_W = slms_pkg::WIN_IDX_W;
  localparam int ROW_W     = slms_pkg::ROW_W;

  slms_pkg::state_t     state, state_next;
  slms_pkg::store_req_t store_req;
  slms_pkg::win_wr_t    win_wr;

  logic [LEN_W-1:0]     msg_len;
  logic signed [8:0]    offset;
  logic [WIN_IDX_W-1:0] cnt;
  logic [ROW_W-1:0]     row;
  logic                 pend;
  logic                 pend_hit;
  logic [WIN_IDX_W-1:0] pend_idx;
  logic [7:0]           rd_data;
  logic [7:0]           row_left, row_middle, row_right;

  logic                 in_take;
  logic                 room;
  logic                 out_load;
  logic [IDX_W-1:0]     idx;
  logic                 idx_hit;

  assign in_take  = in_valid && !in_stall;
  assign room     = msg_len < LEN_W'(slms_pkg::MSG_DEPTH);
  assign out_load = (state == slms_pkg::ST_REFRESH) && (!out_valid || !out_stall);

  // shared index unit: message index of the window column under load
  assign idx = {{(IDX_W-9){offset[8]}}, offset} + {{(IDX_W-WIN_IDX_W){1'b0}}, cnt};
  assign idx_hit = !idx[IDX_W-1] && (idx[IDX_W-2:0] < (IDX_W-1)'(msg_len));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    in_stall          = 1'b1;
    store_req.wr_en   = 1'b0;
    store_req.wr_addr = msg_len[ADDR_W-1:0];
    store_req.wr_data = '0;
    store_req.rd_en   = 1'b0;
    store_req.rd_addr = idx[ADDR_W-1:0];
    unique case (state)
      slms_pkg::ST_IDLE: begin
        in_stall = rst;
        if (in_valid) begin
          unique case (cmd)
            slms_pkg::CMD_CLEAR: ;
            slms_pkg::CMD_APPEND: begin
              store_req.wr_en   = room;
              store_req.wr_data = column_byte;
              if (glyph_end) state_next = slms_pkg::ST_SPACER;
            end
            slms_pkg::CMD_SCROLL:  state_next = slms_pkg::ST_SCROLL;
            slms_pkg::CMD_REFRESH: state_next = slms_pkg::ST_REFRESH;
            default: ;
          endcase
        end
      end
      slms_pkg::ST_SPACER: begin
        store_req.wr_en = room;
        state_next      = slms_pkg::ST_IDLE;
      end
      slms_pkg::ST_SCROLL: begin
        store_req.rd_en = idx_hit;
        if (cnt == WIN_IDX_W'(slms_pkg::WIN_COLS - 1)) state_next = slms_pkg::ST_IDLE;
      end
      slms_pkg::ST_REFRESH: begin
        if (out_load && row == ROW_W'(slms_pkg::ROWS - 1)) state_next = slms_pkg::ST_IDLE;
      end
      default: state_next = slms_pkg::ST_IDLE;
    endcase
  end

  // message length and scroll offset
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_len <= '0;
    end else if (in_take && cmd == slms_pkg::CMD_CLEAR) begin
      msg_len <= '0;
    end else if (store_req.wr_en) begin
      msg_len <= msg_len + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && cmd == slms_pkg::CMD_SCROLL) begin
      offset <= scroll_offset;
    end
  end

  // column and row counters, pending window write behind the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      row  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= (state == slms_pkg::ST_SCROLL);
      if (state == slms_pkg::ST_SCROLL) begin
        cnt <= (state_next == slms_pkg::ST_IDLE) ? '0 : cnt + WIN_IDX_W'(1);
      end
      if (out_load) begin
        row <= row + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_hit <= idx_hit;
    pend_idx <= cnt;
  end

  assign win_wr.en   = pend;
  assign win_wr.idx  = pend_idx;
  assign win_wr.data = pend_hit ? rd_data : 8'h00;

  slms_msg_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

  slms_window u_window (
    .clk        (clk),
    .rst        (rst),
    .wr         (win_wr),
    .row        (row),
    .row_left   (row_left),
    .row_middle (row_middle),
    .row_right  (row_right)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_select  <= 8'(1) << row;
      cols_left   <= row_left;
      cols_middle <= row_middle;
      cols_right  <= row_right;
      last_row    <= (row == ROW_W'(slms_pkg::ROWS - 1));
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    msg_len <= LEN_W'(slms_pkg::MSG_DEPTH))
    else $error("message length beyond store depth");

  a_last_row_sel: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_row |-> row_select == 8'h80)
    else $error("last row flag without row seven select");

  a_no_win_wr_in_refresh: assert property (@(posedge clk) disable iff (rst)
    win_wr.en |-> state != slms_pkg::ST_REFRESH)
    else $error("window written during refresh");

  a_scroll_done: assert property (@(posedge clk) disable iff (rst)
    state == slms_pkg::ST_SCROLL && cnt == WIN_IDX_W'(slms_pkg::WIN_COLS - 1)
    |=> state == slms_pkg::ST_IDLE && pend)
    else $error("scroll did not end after the last window column");
`endif

endmodule
